// ===== hw/rtl/fdc_pkg.sv =====
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types, codes and helpers for the Drude metal FDTD cell update core.
// ----------------------------------------------------------------------------
package fdc_pkg;

  typedef enum logic {
    OP_E = 1'b0,
    OP_H = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_E_GAIN  = 3'd0,
    CFG_H_GAIN  = 3'd1,
    CFG_INV_DX  = 3'd2,
    CFG_INV_DY  = 3'd3,
    CFG_INV_DZ  = 3'd4,
    CFG_J_DECAY = 3'd5,
    CFG_J_DRIVE = 3'd6
  } cfg_reg_t;

  localparam logic signed [31:0] ONE_Q16  = 32'sd65536;
  localparam logic signed [31:0] ZERO_Q16 = 32'sd0;
  localparam logic signed [31:0] Q_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN    = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] val;
    logic               clip;
  } sat_t;

  typedef struct packed {
    logic signed [31:0] field_new;
    logic               saturated;
  } res_t;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [FIFO_CNT_W-1:0] count;
    logic                  empty;
  } fifo_stat_t;

  // Clamp a wide signed value to 32 bits and flag any clipping.
  function automatic sat_t sat32(input logic signed [63:0] x);
    sat_t r;
    if ((x[63:31] == '0) || (x[63:31] == '1)) begin
      r.val  = x[31:0];
      r.clip = 1'b0;
    end else begin
      r.val  = x[63] ? Q_MIN : Q_MAX;
      r.clip = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/fdc_in_if.sv =====
// ----------------------------------------------------------------------------
// fdc_in_if
// Input channel: one cell update request per item.
// ----------------------------------------------------------------------------
interface fdc_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [1:0]         axis;
  logic [11:0]        cell_index;
  logic signed [31:0] field_old;
  logic signed [31:0] j_pos;
  logic signed [31:0] j_neg;
  logic signed [31:0] k_pos;
  logic signed [31:0] k_neg;

  modport source (
    output valid, op, axis, cell_index, field_old, j_pos, j_neg, k_pos, k_neg,
    input  ready
  );
  modport sink (
    input  valid, op, axis, cell_index, field_old, j_pos, j_neg, k_pos, k_neg,
    output ready
  );
endinterface

// ===== hw/rtl/fdc_out_if.sv =====
// ----------------------------------------------------------------------------
// fdc_out_if
// Result channel: one updated field component per item.
// ----------------------------------------------------------------------------
interface fdc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] field_new;
  logic               saturated;

  modport source (output valid, field_new, saturated, input ready);
  modport sink (input valid, field_new, saturated, output ready);
endinterface

// ===== hw/rtl/fdc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// fdc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface fdc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [fdc_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/fdc_ram.sv =====
// ----------------------------------------------------------------------------
// fdc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 12288
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/fdc_result_fifo.sv =====
// ----------------------------------------------------------------------------
// fdc_result_fifo
// Small result queue that decouples the pipeline from the output handshake.
// ----------------------------------------------------------------------------
module fdc_result_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fdc_pkg::res_t       push_data,
  input  logic                pop,
  output fdc_pkg::res_t       pop_data,
  output fdc_pkg::fifo_stat_t stat
);

  fdc_pkg::res_t                   mem_r [fdc_pkg::FIFO_DEPTH];
  logic [fdc_pkg::FIFO_PTR_W-1:0]  wr_ptr_r;
  logic [fdc_pkg::FIFO_PTR_W-1:0]  rd_ptr_r;
  logic [fdc_pkg::FIFO_CNT_W-1:0]  count_r;
  logic [fdc_pkg::FIFO_CNT_W-1:0]  count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = mem_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);

endmodule

// ===== hw/rtl/fdtd_drude_cell_update_core.sv =====
// ----------------------------------------------------------------------------
// fdtd_drude_cell_update_core
// Drude metal FDTD cell update: E update with polarisation current, H update.
// ----------------------------------------------------------------------------
//
//   channel   direction  carries
//   cfg_ch    in         register index, 32-bit write data
//   in_ch     in         op, axis, cell_index, field_old, j/k neighbour pairs
//   out_ch    out        field_new, saturated
//
// One item is taken per cycle while input is not held; each result passes
// through the pipeline stages into the result buffer. The current store is
// a single RAM read at acceptance and written back from the fifth stage, so
// an E item for a cell whose current is in flight waits for that write-back.
// After reset a clearing pass zeroes all 3*CELLS entries of the current store;
// no item is taken meanwhile, while configuration writes are taken throughout.
// Results queue in an eight-entry buffer; input is also held when the buffer
// and the items in flight would overfill it.
// ----------------------------------------------------------------------------
module fdtd_drude_cell_update_core #(
  parameter int CELLS = 4096
) (
  input  logic     clk,
  input  logic     rst_n,
  fdc_cfg_if.sink  cfg_ch,
  fdc_in_if.sink   in_ch,
  fdc_out_if.source out_ch
);

  localparam int DEPTH = 3 * CELLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NSTG  = 5;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [31:0] e_gain_r, h_gain_r, inv_dx_r, inv_dy_r, inv_dz_r;
  logic signed [31:0] j_decay_r, j_drive_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_gain_r  <= fdc_pkg::ONE_Q16;
      h_gain_r  <= fdc_pkg::ONE_Q16;
      inv_dx_r  <= fdc_pkg::ONE_Q16;
      inv_dy_r  <= fdc_pkg::ONE_Q16;
      inv_dz_r  <= fdc_pkg::ONE_Q16;
      j_decay_r <= fdc_pkg::ZERO_Q16;
      j_drive_r <= fdc_pkg::ZERO_Q16;
    end else if (cfg_ch.valid) begin
      case (fdc_pkg::cfg_reg_t'(cfg_ch.index))
        fdc_pkg::CFG_E_GAIN:  e_gain_r  <= cfg_ch.data;
        fdc_pkg::CFG_H_GAIN:  h_gain_r  <= cfg_ch.data;
        fdc_pkg::CFG_INV_DX:  inv_dx_r  <= cfg_ch.data;
        fdc_pkg::CFG_INV_DY:  inv_dy_r  <= cfg_ch.data;
        fdc_pkg::CFG_INV_DZ:  inv_dz_r  <= cfg_ch.data;
        fdc_pkg::CFG_J_DECAY: j_decay_r <= cfg_ch.data;
        fdc_pkg::CFG_J_DRIVE: j_drive_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Clearing pass over the current store
  // --------------------------------------------------------------------------
  logic          clear_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r    <= 1'b1;
      clr_addr_r <= '0;
    end else if (clear_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clear_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input decode, interlock and credit
  // --------------------------------------------------------------------------
  fdc_pkg::axis_t     in_axis;
  logic               in_cell_ok;
  logic               in_wr;
  logic [AW-1:0]      in_addr;
  logic signed [32:0] in_dj, in_dk;
  logic               hazard;
  logic               accept;

  logic [NSTG-1:0]    st_v_r;
  logic [NSTG-1:0]    st_wr_r;
  logic [AW-1:0]      st_addr_r [NSTG];

  fdc_pkg::fifo_stat_t           fifo_stat;
  logic [fdc_pkg::FIFO_CNT_W-1:0] occupancy;

  always_comb begin
    // The unused axis code behaves as z.
    in_axis = (in_ch.axis > fdc_pkg::AXIS_Z) ? fdc_pkg::AXIS_Z
                                             : fdc_pkg::axis_t'(in_ch.axis);
    in_cell_ok = int'(in_ch.cell_index) < CELLS;
    in_wr = (fdc_pkg::op_t'(in_ch.op) == fdc_pkg::OP_E) && in_cell_ok;
    in_addr = AW'(int'(in_axis) * CELLS + (in_cell_ok ? int'(in_ch.cell_index) : 0));
    in_dj = 33'(in_ch.j_pos) - 33'(in_ch.j_neg);
    in_dk = 33'(in_ch.k_pos) - 33'(in_ch.k_neg);
    hazard = 1'b0;
    for (int k = 0; k < NSTG; k++) begin
      if (st_wr_r[k] && (st_addr_r[k] == in_addr)) begin
        hazard = 1'b1;
      end
    end
    occupancy = fifo_stat.count + fdc_pkg::FIFO_CNT_W'($countones(st_v_r));
  end

  assign in_ch.ready = !clear_r && !(in_wr && hazard)
                       && (occupancy < fdc_pkg::FIFO_CNT_W'(fdc_pkg::FIFO_DEPTH));
  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r  <= '0;
      st_wr_r <= '0;
    end else begin
      st_v_r  <= {st_v_r[NSTG-2:0], accept};
      st_wr_r <= {st_wr_r[NSTG-2:0], accept && in_wr};
    end
  end

  always_ff @(posedge clk) begin
    st_addr_r[0] <= in_addr;
    for (int k = 1; k < NSTG; k++) begin
      st_addr_r[k] <= st_addr_r[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Current store
  // --------------------------------------------------------------------------
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [31:0]   ram_rdata;
  fdc_pkg::sat_t j_sat;

  assign ram_we    = clear_r || st_wr_r[NSTG-1];
  assign ram_waddr = clear_r ? clr_addr_r : st_addr_r[NSTG-1];
  assign ram_wdata = clear_r ? '0 : j_sat.val;

  fdc_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage 1: coefficient products, current products
  // --------------------------------------------------------------------------
  fdc_pkg::op_t       s1_op_r;
  fdc_pkg::axis_t     s1_axis_r;
  logic               s1_jv_r;
  logic signed [31:0] s1_f_r;
  logic signed [32:0] s1_dj_r, s1_dk_r;

  always_ff @(posedge clk) begin
    s1_op_r   <= fdc_pkg::op_t'(in_ch.op);
    s1_axis_r <= in_axis;
    s1_jv_r   <= in_wr;
    s1_f_r    <= in_ch.field_old;
    s1_dj_r   <= in_dj;
    s1_dk_r   <= in_dk;
  end

  logic signed [31:0] s1_j, s1_gain, s1_d1, s1_d2;
  logic signed [63:0] s1_p1, s1_p2, s1_pe, s1_pd;

  always_comb begin
    s1_j    = s1_jv_r ? $signed(ram_rdata) : fdc_pkg::ZERO_Q16;
    s1_gain = (s1_op_r == fdc_pkg::OP_E) ? e_gain_r : h_gain_r;
    case (s1_axis_r)
      fdc_pkg::AXIS_X: begin
        s1_d1 = inv_dy_r;
        s1_d2 = inv_dz_r;
      end
      fdc_pkg::AXIS_Y: begin
        s1_d1 = inv_dz_r;
        s1_d2 = inv_dx_r;
      end
      default: begin
        s1_d1 = inv_dx_r;
        s1_d2 = inv_dy_r;
      end
    endcase
    s1_p1 = s1_gain * s1_d1;
    s1_p2 = s1_gain * s1_d2;
    s1_pe = e_gain_r * s1_j;
    s1_pd = j_decay_r * s1_j;
  end

  // --------------------------------------------------------------------------
  // Stage 2: saturate coefficients, curl products
  // --------------------------------------------------------------------------
  fdc_pkg::op_t       s2_op_r;
  logic signed [31:0] s2_f_r;
  logic signed [32:0] s2_dj_r, s2_dk_r;
  logic signed [63:0] s2_p1_r, s2_p2_r;
  logic signed [47:0] s2_te_r, s2_td_r;

  always_ff @(posedge clk) begin
    s2_op_r <= s1_op_r;
    s2_f_r  <= s1_f_r;
    s2_dj_r <= s1_dj_r;
    s2_dk_r <= s1_dk_r;
    s2_p1_r <= s1_p1;
    s2_p2_r <= s1_p2;
    s2_te_r <= $signed(s1_pe[63:16]);
    s2_td_r <= $signed(s1_pd[63:16]);
  end

  fdc_pkg::sat_t      s2_c1, s2_c2;
  logic signed [31:0] s2_c1v, s2_c2v;
  logic signed [64:0] s2_m1, s2_m2;

  always_comb begin
    s2_c1  = fdc_pkg::sat32(64'($signed(s2_p1_r[63:16])));
    s2_c2  = fdc_pkg::sat32(64'($signed(s2_p2_r[63:16])));
    s2_c1v = s2_c1.val;
    s2_c2v = s2_c2.val;
    s2_m1  = s2_c1v * s2_dk_r;
    s2_m2  = s2_c2v * s2_dj_r;
  end

  // --------------------------------------------------------------------------
  // Stage 3: field sum and saturation
  // --------------------------------------------------------------------------
  fdc_pkg::op_t       s3_op_r;
  logic signed [31:0] s3_f_r;
  logic signed [64:0] s3_m1_r, s3_m2_r;
  logic signed [47:0] s3_te_r, s3_td_r;
  logic               s3_clip_r;

  always_ff @(posedge clk) begin
    s3_op_r   <= s2_op_r;
    s3_f_r    <= s2_f_r;
    s3_m1_r   <= s2_m1;
    s3_m2_r   <= s2_m2;
    s3_te_r   <= s2_te_r;
    s3_td_r   <= s2_td_r;
    s3_clip_r <= s2_c1.clip || s2_c2.clip;
  end

  logic signed [48:0] s3_t1, s3_t2;
  logic signed [51:0] s3_sum;
  fdc_pkg::sat_t      s3_res;

  always_comb begin
    s3_t1 = $signed(s3_m1_r[64:16]);
    s3_t2 = $signed(s3_m2_r[64:16]);
    if (s3_op_r == fdc_pkg::OP_E) begin
      s3_sum = 52'(s3_f_r) + 52'(s3_t1) - 52'(s3_t2) - 52'(s3_te_r);
    end else begin
      s3_sum = 52'(s3_f_r) + 52'(s3_t2) - 52'(s3_t1);
    end
    s3_res = fdc_pkg::sat32(64'(s3_sum));
  end

  // --------------------------------------------------------------------------
  // Stage 4: current drive product
  // --------------------------------------------------------------------------
  fdc_pkg::op_t       s4_op_r;
  logic signed [31:0] s4_res_r;
  logic signed [47:0] s4_td_r;
  logic               s4_clip_r;

  always_ff @(posedge clk) begin
    s4_op_r   <= s3_op_r;
    s4_res_r  <= s3_res.val;
    s4_td_r   <= s3_td_r;
    s4_clip_r <= s3_clip_r || s3_res.clip;
  end

  logic signed [63:0] s4_pr;

  assign s4_pr = j_drive_r * s4_res_r;

  // --------------------------------------------------------------------------
  // Stage 5: new current, write-back and result push
  // --------------------------------------------------------------------------
  fdc_pkg::op_t       s5_op_r;
  logic signed [31:0] s5_res_r;
  logic signed [47:0] s5_td_r;
  logic signed [63:0] s5_pr_r;
  logic               s5_clip_r;

  always_ff @(posedge clk) begin
    s5_op_r   <= s4_op_r;
    s5_res_r  <= s4_res_r;
    s5_td_r   <= s4_td_r;
    s5_pr_r   <= s4_pr;
    s5_clip_r <= s4_clip_r;
  end

  logic signed [48:0] s5_jn;
  fdc_pkg::res_t      s5_result;

  always_comb begin
    s5_jn = 49'(s5_td_r) + 49'($signed(s5_pr_r[63:16]));
    j_sat = fdc_pkg::sat32(64'(s5_jn));
    s5_result.field_new = s5_res_r;
    // The current is advanced, and may clip, even for a cell outside the store.
    s5_result.saturated = s5_clip_r || ((s5_op_r == fdc_pkg::OP_E) && j_sat.clip);
  end

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  fdc_pkg::res_t out_item;
  logic          out_pop;

  assign out_pop = out_ch.valid && out_ch.ready;

  fdc_result_fifo u_result_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (st_v_r[NSTG-1]),
    .push_data (s5_result),
    .pop       (out_pop),
    .pop_data  (out_item),
    .stat      (fifo_stat)
  );

  assign out_ch.valid     = !fifo_stat.empty;
  assign out_ch.field_new = out_item.field_new;
  assign out_ch.saturated = out_item.saturated;

`ifndef SYNTHESIS
  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !clear_r)
    else $error("item accepted during the clearing pass");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(fifo_stat.count) + $countones(st_v_r)) <= fdc_pkg::FIFO_DEPTH)
    else $error("result queue credit exceeded");

  a_no_current_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    st_wr_r[0] |-> !((st_wr_r[1] && (st_addr_r[1] == st_addr_r[0]))
                  || (st_wr_r[2] && (st_addr_r[2] == st_addr_r[0]))
                  || (st_wr_r[3] && (st_addr_r[3] == st_addr_r[0]))
                  || (st_wr_r[4] && (st_addr_r[4] == st_addr_r[0]))))
    else $error("current read overlaps a pending write-back");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    st_v_r[NSTG-1] |-> (32'(fifo_stat.count) < fdc_pkg::FIFO_DEPTH))
    else $error("result pushed into a full queue");
`endif

endmodule

// ===== sim/tb_fdtd_drude_cell_update_core.sv =====
// ----------------------------------------------------------------------------
// tb_fdtd_drude_cell_update_core
// Self-checking bench for the Drude metal FDTD cell update core. A local
// fixed-point predictor, with its own copy of the registers and current store,
// works out each result when an item is accepted. A checker compares every
// result with the oldest prediction. Directed items cover extremes, both
// operations, the spare axis code and cells beyond the store. Random phases
// follow under several register settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_fdtd_drude_cell_update_core;

  // A store smaller than the cell field lets items address cells beyond it.
  localparam int NCELLS        = 3072;
  localparam int STORE_DEPTH   = 3 * NCELLS;
  localparam int IDLE_LIMIT    = 40000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 130;

  localparam logic [fdc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [1:0]           AXIS_SPARE = 2'd3;
  localparam logic signed [79:0]   WIDE_MAX   = 80'sh7FFF_FFFF;
  localparam logic signed [79:0]   WIDE_MIN   = -80'sh8000_0000;

  typedef struct {
    fdc_pkg::op_t       op;
    logic [1:0]         axis;
    logic [11:0]        cell_no;
    logic signed [31:0] field_old;
    logic signed [31:0] j_pos;
    logic signed [31:0] j_neg;
    logic signed [31:0] k_pos;
    logic signed [31:0] k_neg;
  } cell_req_t;

  typedef struct {
    logic signed [31:0] field_new;
    logic               saturated;
  } cell_res_t;

  logic clk;
  logic rst_n;

  fdc_cfg_if cfg_ch ();
  fdc_in_if  in_ch ();
  fdc_out_if out_ch ();

  fdtd_drude_cell_update_core #(
    .CELLS(NCELLS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  logic signed [31:0] coeff [0:6];
  logic signed [31:0] current_mirror [0:STORE_DEPTH-1];
  cell_res_t          field_expect_q [$];
  int                 mismatches;
  int                 idle_cycles;
  bit                 steady;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Full product of two Q16.16 values with the low 16 bits floored away.
  function automatic logic signed [79:0] qprod(input logic signed [79:0] a,
                                               input logic signed [79:0] b);
    logic signed [79:0] p;
    p = a * b;
    return p >>> 16;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [79:0] x,
                                                 inout bit clip);
    if (x > WIDE_MAX) begin
      clip = 1'b1;
      return fdc_pkg::Q_MAX;
    end
    if (x < WIDE_MIN) begin
      clip = 1'b1;
      return fdc_pkg::Q_MIN;
    end
    return x[31:0];
  endfunction

  function automatic cell_res_t update_cell(input cell_req_t req);
    cell_res_t          r;
    logic [1:0]         ax;
    logic signed [31:0] d1, d2, c1, c2, j_now, j_next;
    logic signed [79:0] dj, dk, acc;
    bit                 clip;
    bit                 in_store;
    int                 addr;
    clip = 1'b0;
    ax = (req.axis == AXIS_SPARE) ? fdc_pkg::AXIS_Z : req.axis;
    case (ax)
      fdc_pkg::AXIS_X: begin
        d1 = coeff[fdc_pkg::CFG_INV_DY];
        d2 = coeff[fdc_pkg::CFG_INV_DZ];
      end
      fdc_pkg::AXIS_Y: begin
        d1 = coeff[fdc_pkg::CFG_INV_DZ];
        d2 = coeff[fdc_pkg::CFG_INV_DX];
      end
      default: begin
        d1 = coeff[fdc_pkg::CFG_INV_DX];
        d2 = coeff[fdc_pkg::CFG_INV_DY];
      end
    endcase
    dj = req.j_pos - req.j_neg;
    dk = req.k_pos - req.k_neg;
    if (req.op == fdc_pkg::OP_E) begin
      in_store = req.cell_no < NCELLS;
      addr = ax * NCELLS + req.cell_no;
      j_now = in_store ? current_mirror[addr] : fdc_pkg::ZERO_Q16;
      c1 = clamp32(qprod(coeff[fdc_pkg::CFG_E_GAIN], d1), clip);
      c2 = clamp32(qprod(coeff[fdc_pkg::CFG_E_GAIN], d2), clip);
      acc = req.field_old + qprod(c1, dk) - qprod(c2, dj)
            - qprod(coeff[fdc_pkg::CFG_E_GAIN], j_now);
      r.field_new = clamp32(acc, clip);
      j_next = clamp32(qprod(coeff[fdc_pkg::CFG_J_DECAY], j_now)
                       + qprod(coeff[fdc_pkg::CFG_J_DRIVE], r.field_new), clip);
      if (in_store) current_mirror[addr] = j_next;
    end else begin
      c1 = clamp32(qprod(coeff[fdc_pkg::CFG_H_GAIN], d1), clip);
      c2 = clamp32(qprod(coeff[fdc_pkg::CFG_H_GAIN], d2), clip);
      acc = req.field_old + qprod(c2, dj) - qprod(c1, dk);
      r.field_new = clamp32(acc, clip);
    end
    r.saturated = clip;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one; none in steady stretches.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] rand_val(input bit wide);
    logic signed [31:0] v;
    case ($urandom_range(0, 19))
      0: v = fdc_pkg::Q_MAX;
      1: v = fdc_pkg::Q_MIN;
      2: v = fdc_pkg::ZERO_Q16;
      default: begin
        if (wide) v = $urandom;
        else v = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      end
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] rand_coeff(input int mode);
    logic signed [31:0] v;
    if (mode == 0) begin
      v = $urandom_range(0, 2 * 65536);
    end else if (mode == 1) begin
      v = $urandom;
    end else begin
      case ($urandom_range(0, 4))
        0: v = fdc_pkg::Q_MAX;
        1: v = fdc_pkg::Q_MIN;
        2: v = fdc_pkg::ZERO_Q16;
        3: v = fdc_pkg::ONE_Q16;
        default: v = -fdc_pkg::ONE_Q16;
      endcase
    end
    return v;
  endfunction

  function automatic cell_req_t make_req(input fdc_pkg::op_t op, input logic [1:0] axis,
                                         input logic [11:0] cell_no,
                                         input logic signed [31:0] f,
                                         input logic signed [31:0] jp,
                                         input logic signed [31:0] jn,
                                         input logic signed [31:0] kp,
                                         input logic signed [31:0] kn);
    cell_req_t q;
    q.op = op;
    q.axis = axis;
    q.cell_no = cell_no;
    q.field_old = f;
    q.j_pos = jp;
    q.j_neg = jn;
    q.k_pos = kp;
    q.k_neg = kn;
    return q;
  endfunction

  // Most items are plausible updates, half of them on a few hot cells, so that
  // the current builds up and in-flight cells collide; the rest is unrestricted noise.
  function automatic cell_req_t rand_req();
    cell_req_t q;
    bit        wide;
    if ($urandom_range(0, 9) < 7) begin
      q.op = ($urandom_range(0, 2) == 0) ? fdc_pkg::OP_H : fdc_pkg::OP_E;
      q.axis = 2'($urandom_range(0, 2));
      if ($urandom_range(0, 1) == 1) q.cell_no = 12'($urandom_range(0, 7));
      else q.cell_no = 12'($urandom_range(0, NCELLS - 1));
      wide = 1'b0;
    end else begin
      q.op = ($urandom_range(0, 1) == 1) ? fdc_pkg::OP_H : fdc_pkg::OP_E;
      q.axis = 2'($urandom_range(0, 3));
      q.cell_no = 12'($urandom);
      wide = 1'b1;
    end
    q.field_old = rand_val(wide);
    q.j_pos = rand_val(wide);
    q.j_neg = rand_val(wide);
    q.k_pos = rand_val(wide);
    q.k_neg = rand_val(wide);
    return q;
  endfunction

  task automatic send_cell(input cell_req_t req);
    in_ch.valid      <= 1'b1;
    in_ch.op         <= req.op;
    in_ch.axis       <= req.axis;
    in_ch.cell_index <= req.cell_no;
    in_ch.field_old  <= req.field_old;
    in_ch.j_pos      <= req.j_pos;
    in_ch.j_neg      <= req.j_neg;
    in_ch.k_pos      <= req.k_pos;
    in_ch.k_neg      <= req.k_neg;
    do @(posedge clk); while (!in_ch.ready);
    field_expect_q.push_back(update_cell(req));
  endtask

  task automatic pause_in(input int cycles);
    if (cycles > 0) begin
      in_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (field_expect_q.size() != 0);
  endtask

  task automatic write_reg(input logic [fdc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx <= fdc_pkg::CFG_J_DRIVE) coeff[idx] = val;
  endtask

  task automatic end_writes();
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic signed [31:0] eg, input logic signed [31:0] hg,
                              input logic signed [31:0] dx, input logic signed [31:0] dy,
                              input logic signed [31:0] dz, input logic signed [31:0] jd,
                              input logic signed [31:0] jv);
    write_reg(fdc_pkg::CFG_E_GAIN, eg);
    write_reg(fdc_pkg::CFG_H_GAIN, hg);
    write_reg(fdc_pkg::CFG_INV_DX, dx);
    write_reg(fdc_pkg::CFG_INV_DY, dy);
    write_reg(fdc_pkg::CFG_INV_DZ, dz);
    write_reg(fdc_pkg::CFG_J_DECAY, jd);
    write_reg(fdc_pkg::CFG_J_DRIVE, jv);
    end_writes();
  endtask

  // Reset settings: both operations, the spare axis code, cells at and beyond
  // the end of the store, and curls large enough to clip the field.
  task automatic test_reset_settings();
    send_cell(make_req(fdc_pkg::OP_E, fdc_pkg::AXIS_X, 12'd0, fdc_pkg::ONE_Q16,
                       32'sh0002_0000, fdc_pkg::ZERO_Q16,
                       fdc_pkg::ONE_Q16, -fdc_pkg::ONE_Q16));
    send_cell(make_req(fdc_pkg::OP_H, fdc_pkg::AXIS_Y, 12'd5, -fdc_pkg::ONE_Q16,
                       fdc_pkg::Q_MAX, fdc_pkg::Q_MIN,
                       fdc_pkg::ZERO_Q16, fdc_pkg::ZERO_Q16));
    send_cell(make_req(fdc_pkg::OP_E, fdc_pkg::AXIS_Z, 12'(NCELLS - 1), fdc_pkg::Q_MIN,
                       fdc_pkg::ZERO_Q16, fdc_pkg::ZERO_Q16,
                       fdc_pkg::Q_MIN, fdc_pkg::Q_MAX));
    send_cell(make_req(fdc_pkg::OP_E, AXIS_SPARE, 12'(NCELLS), fdc_pkg::Q_MAX,
                       fdc_pkg::Q_MIN, fdc_pkg::Q_MAX,
                       fdc_pkg::ONE_Q16, fdc_pkg::ZERO_Q16));
    send_cell(make_req(fdc_pkg::OP_E, fdc_pkg::AXIS_X, 12'hFFF, 32'sh1234_5678,
                       fdc_pkg::ONE_Q16, fdc_pkg::ONE_Q16,
                       fdc_pkg::Q_MAX, fdc_pkg::Q_MIN));
    send_cell(make_req(fdc_pkg::OP_H, AXIS_SPARE, 12'hFFF, fdc_pkg::Q_MAX,
                       fdc_pkg::Q_MAX, fdc_pkg::Q_MIN,
                       fdc_pkg::Q_MIN, fdc_pkg::Q_MAX));
  endtask

  // Extreme registers clip the coefficients themselves; a write to the unused
  // index must leave every register as it was.
  task automatic test_extreme_registers();
    int i;
    drain_results();
    program_regs(fdc_pkg::Q_MIN, fdc_pkg::Q_MAX, fdc_pkg::Q_MAX, fdc_pkg::Q_MIN,
                 fdc_pkg::ONE_Q16, fdc_pkg::Q_MAX, fdc_pkg::Q_MIN);
    write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
    end_writes();
    for (i = 0; i < 8; i++) begin
      send_cell(make_req(i[0] ? fdc_pkg::OP_H : fdc_pkg::OP_E, 2'(i), 12'(i >> 1),
                         i[1] ? fdc_pkg::Q_MAX : fdc_pkg::Q_MIN,
                         i[2] ? fdc_pkg::Q_MIN : fdc_pkg::Q_MAX, fdc_pkg::Q_MAX,
                         i[1] ? fdc_pkg::ZERO_Q16 : fdc_pkg::Q_MIN,
                         i[0] ? fdc_pkg::Q_MAX : -fdc_pkg::ONE_Q16));
      pause_in(pick_gap());
    end
  endtask

  // Back-to-back E items on one cell number, so each must see the current
  // that the one before it on its axis left, with another axis between.
  task automatic test_current_chain();
    int i;
    drain_results();
    program_regs(32'sh0000_2000, fdc_pkg::ONE_Q16, fdc_pkg::ONE_Q16, 32'sh0002_0000,
                 32'sh0000_8000, 32'sh0000_E000, 32'sh0000_4000);
    steady = 1'b1;
    for (i = 0; i < 8; i++)
      send_cell(make_req(fdc_pkg::OP_E, (i % 3 == 2) ? fdc_pkg::AXIS_X : fdc_pkg::AXIS_Y,
                         12'd3, 32'sh0001_0000 * (i + 1), fdc_pkg::ONE_Q16,
                         -fdc_pkg::ONE_Q16, 32'sh0000_8000, fdc_pkg::ZERO_Q16));
    steady = 1'b0;
  endtask

  task automatic test_random_phases();
    int phase;
    int i;
    int mode;
    for (phase = 0; phase < PHASES; phase++) begin
      mode = phase % 3;
      drain_results();
      steady = 1'b0;
      program_regs(rand_coeff(mode), rand_coeff(mode), rand_coeff(mode), rand_coeff(mode),
                   rand_coeff(mode), rand_coeff(mode), rand_coeff(mode));
      write_reg(CFG_UNUSED, $urandom);
      end_writes();
      steady = (phase % 4 == 1);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        send_cell(rand_req());
        pause_in(pick_gap());
        if ($urandom_range(0, 79) == 0) drain_results();
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    cell_res_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (field_expect_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual field %h saturated %b",
                 $time, out_ch.field_new, out_ch.saturated);
      end else begin
        want = field_expect_q.pop_front();
        if (out_ch.field_new !== want.field_new) begin
          mismatches++;
          $display("%0t: field_new mismatch, expected %h actual %h",
                   $time, want.field_new, out_ch.field_new);
        end
        if (out_ch.saturated !== want.saturated) begin
          mismatches++;
          $display("%0t: saturated mismatch, expected %b actual %b",
                   $time, want.saturated, out_ch.saturated);
        end
      end
    end
  end

  // The clearing pass after reset is the longest stretch with no item moving.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("[fdtd_drude_cell_update_core] ERROR");
      $finish;
    end
  end

  initial begin
    int hold;
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      hold = $urandom_range(1, 24);
      repeat (hold) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    int i;
    mismatches  = 0;
    idle_cycles = 0;
    steady      = 1'b0;
    coeff[fdc_pkg::CFG_E_GAIN]  = fdc_pkg::ONE_Q16;
    coeff[fdc_pkg::CFG_H_GAIN]  = fdc_pkg::ONE_Q16;
    coeff[fdc_pkg::CFG_INV_DX]  = fdc_pkg::ONE_Q16;
    coeff[fdc_pkg::CFG_INV_DY]  = fdc_pkg::ONE_Q16;
    coeff[fdc_pkg::CFG_INV_DZ]  = fdc_pkg::ONE_Q16;
    coeff[fdc_pkg::CFG_J_DECAY] = fdc_pkg::ZERO_Q16;
    coeff[fdc_pkg::CFG_J_DRIVE] = fdc_pkg::ZERO_Q16;
    for (i = 0; i < STORE_DEPTH; i++) current_mirror[i] = fdc_pkg::ZERO_Q16;
    rst_n            <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= fdc_pkg::CFG_E_GAIN;
    cfg_ch.data      <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= fdc_pkg::OP_E;
    in_ch.axis       <= fdc_pkg::AXIS_X;
    in_ch.cell_index <= '0;
    in_ch.field_old  <= fdc_pkg::ZERO_Q16;
    in_ch.j_pos      <= fdc_pkg::ZERO_Q16;
    in_ch.j_neg      <= fdc_pkg::ZERO_Q16;
    in_ch.k_pos      <= fdc_pkg::ZERO_Q16;
    in_ch.k_neg      <= fdc_pkg::ZERO_Q16;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_settings();
    test_extreme_registers();
    test_current_chain();
    test_random_phases();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && field_expect_q.size() == 0)
      $display("[fdtd_drude_cell_update_core] OK");
    else
      $display("[fdtd_drude_cell_update_core] ERROR");
    $finish;
  end

endmodule
